[hdl/mbpfr_pkg.sv]
package mbpfr_pkg;

    // Window depth and the widths that follow from it.
    localparam int MAX_PATTERN_BYTES = 16;
    localparam int WIN_IDX_W         = 4;
    localparam int FILL_W            = 5;
    localparam int PATTERN_W         = 8 * MAX_PATTERN_BYTES;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int OFFSET_W   = 32;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CARE_MASK       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LOW = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_HIGH= 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_MODE    = 3'd6;

    typedef logic [MAX_PATTERN_BYTES-1:0][7:0] window_t;

    // Configuration as seen by the matching engine. The length is already clamped.
    typedef struct packed {
        logic [PATTERN_W-1:0]         pattern;
        logic [PATTERN_W-1:0]         replacement;
        logic [MAX_PATTERN_BYTES-1:0] care_mask;
        logic [FILL_W-1:0]            active_len;
        logic                         replace_mode;
        logic                         wr_pulse;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       region_end;
    } item_t;

    typedef struct packed {
        logic [7:0]          out_byte;
        logic                match_found;
        logic [OFFSET_W-1:0] match_offset;
        logic                last_of_region;
    } result_t;

endpackage

[hdl/mbpfr_cfg_regs.sv]
module mbpfr_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [mbpfr_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
    input  logic [mbpfr_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    output mbpfr_pkg::cfg_t                     cfg
);

    logic [63:0] pattern_low_reg;
    logic [63:0] pattern_high_reg;
    logic [63:0] replacement_low_reg;
    logic [63:0] replacement_high_reg;
    logic [15:0] care_mask_reg;
    logic [4:0]  pattern_length_reg;
    logic        replace_mode_reg;
    logic        known_index;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_low_reg      <= '0;
            pattern_high_reg     <= '0;
            replacement_low_reg  <= '0;
            replacement_high_reg <= '0;
            care_mask_reg        <= 16'hFFFF;
            pattern_length_reg   <= 5'd1;
            replace_mode_reg     <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                mbpfr_pkg::REG_PATTERN_LOW:      pattern_low_reg      <= cfg_wr_data;
                mbpfr_pkg::REG_PATTERN_HIGH:     pattern_high_reg     <= cfg_wr_data;
                mbpfr_pkg::REG_CARE_MASK:        care_mask_reg        <= cfg_wr_data[15:0];
                mbpfr_pkg::REG_PATTERN_LENGTH:   pattern_length_reg   <= cfg_wr_data[4:0];
                mbpfr_pkg::REG_REPLACEMENT_LOW:  replacement_low_reg  <= cfg_wr_data;
                mbpfr_pkg::REG_REPLACEMENT_HIGH: replacement_high_reg <= cfg_wr_data;
                mbpfr_pkg::REG_REPLACE_MODE:     replace_mode_reg     <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_wr_index)
            mbpfr_pkg::REG_PATTERN_LOW,
            mbpfr_pkg::REG_PATTERN_HIGH,
            mbpfr_pkg::REG_CARE_MASK,
            mbpfr_pkg::REG_PATTERN_LENGTH,
            mbpfr_pkg::REG_REPLACEMENT_LOW,
            mbpfr_pkg::REG_REPLACEMENT_HIGH,
            mbpfr_pkg::REG_REPLACE_MODE: known_index = 1'b1;
            default:                     known_index = 1'b0;
        endcase
    end

    // A length of zero acts as one, and anything past the window depth is clamped.
    always_comb begin
        cfg.pattern      = {pattern_high_reg, pattern_low_reg};
        cfg.replacement  = {replacement_high_reg, replacement_low_reg};
        cfg.care_mask    = care_mask_reg;
        cfg.replace_mode = replace_mode_reg;
        cfg.wr_pulse     = cfg_wr_en && known_index;
        if (pattern_length_reg == 5'd0) begin
            cfg.active_len = 5'd1;
        end else if (pattern_length_reg > 5'(mbpfr_pkg::MAX_PATTERN_BYTES)) begin
            cfg.active_len = 5'(mbpfr_pkg::MAX_PATTERN_BYTES);
        end else begin
            cfg.active_len = pattern_length_reg;
        end
    end

endmodule

[hdl/mbpfr_in_stage.sv]
module mbpfr_in_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,
    input  logic                s_tlast,
    input  logic                take,
    output logic                item_valid,
    output mbpfr_pkg::item_t    item
);

    logic             valid_reg;
    logic             valid_next;
    mbpfr_pkg::item_t item_reg;
    logic             load;

    assign s_tready   = !valid_reg || take;
    assign load       = s_tvalid && s_tready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg.data_byte  <= s_tdata;
            item_reg.region_end <= s_tlast;
        end
    end

endmodule

[hdl/mbpfr_engine.sv]
module mbpfr_engine (
    input  logic                aclk,
    input  logic                aresetn,
    input  mbpfr_pkg::cfg_t     cfg,
    input  logic                item_valid,
    input  mbpfr_pkg::item_t    item,
    input  logic                advance,
    output logic                take,
    output logic                emit,
    output mbpfr_pkg::result_t  result
);

    localparam int N = mbpfr_pkg::MAX_PATTERN_BYTES;

    mbpfr_pkg::window_t                 win_reg, win_next;
    logic [mbpfr_pkg::FILL_W-1:0]       fill_reg, fill_next;
    logic [mbpfr_pkg::OFFSET_W-1:0]     pos_reg, pos_next;
    logic                               busy_reg, busy_next;
    logic                               end_reg, end_next;
    logic                               seen_reg, seen_next;

    mbpfr_pkg::window_t                 win_cur;
    mbpfr_pkg::window_t                 win_rep;
    mbpfr_pkg::window_t                 win_out;
    logic [mbpfr_pkg::FILL_W-1:0]       fill_cur;
    logic [mbpfr_pkg::FILL_W-1:0]       fill_dec;
    logic                               end_cur;
    logic                               step;
    logic                               full;
    logic                               flush;
    logic                               hit;
    logic                               flag;
    logic                               last;

    // A new byte is taken only when the previous one has finished all its output.
    assign take = item_valid && advance && !busy_reg;
    assign step = take || (busy_reg && advance);

    always_comb begin
        win_cur  = win_reg;
        fill_cur = fill_reg;
        end_cur  = end_reg;
        if (take) begin
            win_cur[fill_reg[mbpfr_pkg::WIN_IDX_W-1:0]] = item.data_byte;
            fill_cur = fill_reg + 5'd1;
            end_cur  = item.region_end;
        end
    end

    // All positions within the active length are compared and replaced in parallel.
    always_comb begin
        hit     = 1'b1;
        win_rep = win_cur;
        for (int j = 0; j < N; j++) begin
            if (5'(j) < cfg.active_len) begin
                if (cfg.care_mask[j] && (win_cur[j] != cfg.pattern[8*j +: 8])) begin
                    hit = 1'b0;
                end
                win_rep[j] = cfg.replacement[8*j +: 8];
            end
        end
    end

    always_comb begin
        full     = fill_cur >= cfg.active_len;
        flush    = !full && end_cur && (fill_cur != 5'd0);
        emit     = step && (full || flush);
        flag     = full && hit && (cfg.replace_mode || !seen_reg);
        win_out  = (full && hit && cfg.replace_mode) ? win_rep : win_cur;
        last     = end_cur && (fill_cur == 5'd1);
        fill_dec = fill_cur - 5'd1;

        result.out_byte       = win_out[0];
        result.match_found    = flag;
        result.match_offset   = pos_reg;
        result.last_of_region = last;
    end

    always_comb begin
        win_next  = win_reg;
        fill_next = fill_reg;
        pos_next  = pos_reg;
        busy_next = busy_reg;
        end_next  = end_reg;
        if (emit) begin
            if (last) begin
                win_next  = '0;
                fill_next = '0;
                pos_next  = '0;
                busy_next = 1'b0;
                end_next  = 1'b0;
            end else begin
                win_next  = {8'h00, win_out[N-1:1]};
                fill_next = fill_dec;
                pos_next  = pos_reg + 32'd1;
                busy_next = (fill_dec >= cfg.active_len) || end_cur;
                end_next  = end_cur;
            end
        end else if (step) begin
            win_next  = win_cur;
            fill_next = fill_cur;
            busy_next = 1'b0;
            end_next  = end_cur;
        end
    end

    always_comb begin
        seen_next = seen_reg;
        if (cfg.wr_pulse) begin
            seen_next = 1'b0;
        end else if (emit && full && hit && !cfg.replace_mode) begin
            seen_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg  <= '0;
            fill_reg <= '0;
            pos_reg  <= '0;
            busy_reg <= 1'b0;
            end_reg  <= 1'b0;
            seen_reg <= 1'b0;
        end else begin
            win_reg  <= win_next;
            fill_reg <= fill_next;
            pos_reg  <= pos_next;
            busy_reg <= busy_next;
            end_reg  <= end_next;
            seen_reg <= seen_next;
        end
    end

endmodule

[hdl/masked_byte_pattern_find_replace.sv]
// A byte that completes a window passes through the input register and then the output register.
// Throughput: one input transaction and one result transaction per cycle in steady state, while m_tready stays high.
// A region end, or a window left longer than a shortened pattern, gives extra results while no new byte is taken.
// Reset: synchronous, active low on aresetn; clears the window, offset, match memory, and
// configuration registers to their defaults.
module masked_byte_pattern_find_replace (
    input  logic                                aclk,
    input  logic                                aresetn,

    // Input stream. s_tdata: data_byte [7:0]. s_tlast: region_end.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,
    input  logic                                s_tlast,

    // Result stream. m_tdata: out_byte [7:0], match_offset [39:8].
    // m_tuser: match_found [0]. m_tlast: last_of_region.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [39:0]                         m_tdata,
    output logic [0:0]                          m_tuser,
    output logic                                m_tlast,

    // Configuration writes, taken on any cycle with cfg_wr_en high.
    input  logic                                cfg_wr_en,
    input  logic [mbpfr_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
    input  logic [mbpfr_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);

    mbpfr_pkg::cfg_t      cfg;
    mbpfr_pkg::item_t     item;
    mbpfr_pkg::result_t   result;
    mbpfr_pkg::result_t   res_reg;
    logic                 item_valid;
    logic                 take;
    logic                 emit;
    logic                 advance;
    logic                 m_valid_reg;
    logic                 m_valid_next;

    mbpfr_cfg_regs u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    // The input register holds one transaction until the engine absorbs it.
    mbpfr_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    // The engine keeps the sliding window. Each cycle it may append one byte and
    // release the oldest one, compared against the pattern and, in replace mode, replaced on a hit.
    mbpfr_engine u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .advance    (advance),
        .take       (take),
        .emit       (emit),
        .result     (result)
    );

    // The engine only moves when the output register is empty or being drained,
    // so a stalled consumer freezes the window without losing any result.
    assign advance = !m_valid_reg || m_tready;

    always_comb begin
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            res_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {res_reg.match_offset, res_reg.out_byte};
    assign m_tuser  = res_reg.match_found;
    assign m_tlast  = res_reg.last_of_region;

endmodule
